// ===== hdl/nbf_pkg.sv =====
// ---------------------------------------------------------------------------
// nbf_pkg
// Shared types, constants and float helpers for the nonbonded pair force pipe.
// ---------------------------------------------------------------------------
`default_nettype none

package nbf_pkg;

  localparam int DIST_ST  = 5;
  localparam int SQ_ST    = 8;
  localparam int SQ_STEP  = 4;
  localparam int DV_ST    = 8;
  localparam int DV_STEP  = 4;
  localparam int EN_ST    = 11;

  // mantissa in [2^31, 2^32) or zero, value = m * 2^e
  typedef struct packed {
    logic               neg;
    logic signed [11:0] e;
    logic [31:0]        m;
  } flt_t;

  // aligned sum before renormalization
  typedef struct packed {
    logic               byp;
    flt_t               bv;
    logic [62:0]        sum;
    logic signed [11:0] e;
    logic               neg;
  } addp_t;

  localparam flt_t F_ZERO = '{neg: 1'b0, e: 12'sd0, m: 32'd0};
  localparam flt_t F_KC   = '{neg: 1'b0, e: -12'sd24, m: 32'd2330950189};
  localparam flt_t F_EL14 = '{neg: 1'b0, e: -12'sd32, m: 32'd3578996224};
  localparam flt_t F_M1   = '{neg: 1'b1, e: -12'sd31, m: 32'h8000_0000};
  localparam flt_t F_M6   = '{neg: 1'b1, e: -12'sd29, m: 32'hc000_0000};
  localparam flt_t F_C12  = '{neg: 1'b0, e: -12'sd28, m: 32'hc000_0000};

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic [31:0]        mz;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [63:0]        sqz;
    logic [65:0]        rsq;
    logic signed [31:0] qp;
    logic [31:0]        sg2;
    logic [23:0]        eps;
    logic               onefour;
    logic               ljx;
    logic               cut_ok;
    logic               coinc;
    logic signed [7:0]  k;
    logic [63:0]        mm;
    logic [34:0]        srem;
    logic [31:0]        root;
    logic [32:0]        q1;
    logic [32:0]        q2;
    logic [31:0]        rem1;
    logic [31:0]        rem2;
    flt_t               qq;
    flt_t               sg2f;
    flt_t               a;
    flt_t               fdx;
    flt_t               fdy;
    flt_t               fdz;
    flt_t               r;
    flt_t               r2;
    flt_t               ir;
    flt_t               ir2;
    flt_t               ec;
    flt_t               u;
    flt_t               uu;
    flt_t               u3;
    flt_t               au3;
    flt_t               x12;
    flt_t               u3m1;
    flt_t               t;
    flt_t               el;
    flt_t               au3t;
    flt_t               ljf;
    flt_t               coef;
    flt_t               fx;
    flt_t               fy;
    flt_t               fz;
    addp_t              p1;
    addp_t              p2;
    addp_t              cp;
  } pipe_t;

  function automatic flt_t fnorm(input logic [63:0] x, input logic signed [11:0] e,
                                 input logic neg);
    flt_t       f;
    logic [5:0] p;
    logic [63:0] y;
    f = F_ZERO;
    p = '0;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    if (x != '0) begin
      if (p >= 6'd31) y = x >> (p - 6'd31);
      else y = x << (6'd31 - p);
      f.m   = y[31:0];
      f.e   = e + $signed({6'b0, p}) - 12'sd31;
      f.neg = neg;
    end
    return f;
  endfunction

  function automatic flt_t fmul(input flt_t a, input flt_t b);
    flt_t        f;
    logic [63:0] p;
    f = F_ZERO;
    p = 64'(a.m) * 64'(b.m);
    if (p != '0) begin
      f.neg = a.neg ^ b.neg;
      if (p[63]) begin
        f.m = p[63:32];
        f.e = a.e + b.e + 12'sd32;
      end else begin
        f.m = p[62:31];
        f.e = a.e + b.e + 12'sd31;
      end
    end
    return f;
  endfunction

  function automatic addp_t fadd_pre(input flt_t a, input flt_t b);
    addp_t              r;
    logic signed [12:0] d;
    logic [12:0]        sh;
    logic [61:0]        ma;
    logic [61:0]        mb;
    r  = '0;
    ma = {a.m, 30'b0};
    mb = {b.m, 30'b0};
    d  = $signed({a.e[11], a.e}) - $signed({b.e[11], b.e});
    sh = '0;
    if (a.m == '0) begin
      r.byp = 1'b1;
      r.bv  = b;
    end else if (b.m == '0) begin
      r.byp = 1'b1;
      r.bv  = a;
    end else begin
      if (d >= 13'sd0) begin
        r.e = a.e;
        sh  = $unsigned(d);
        mb  = (sh >= 13'd63) ? '0 : (mb >> sh);
      end else begin
        r.e = b.e;
        sh  = $unsigned(-d);
        ma  = (sh >= 13'd63) ? '0 : (ma >> sh);
      end
      if (a.neg == b.neg) begin
        r.sum = {1'b0, ma} + {1'b0, mb};
        r.neg = a.neg;
      end else if (ma >= mb) begin
        r.sum = {1'b0, ma - mb};
        r.neg = a.neg;
      end else begin
        r.sum = {1'b0, mb - ma};
        r.neg = b.neg;
      end
    end
    return r;
  endfunction

  function automatic flt_t fadd_post(input addp_t p);
    flt_t f;
    if (p.byp) f = p.bv;
    else f = fnorm({1'b0, p.sum}, p.e - 12'sd30, p.neg);
    return f;
  endfunction

  // truncate toward zero into Q31.32, saturating
  function automatic logic [63:0] to_q32(input flt_t x);
    logic signed [12:0] sh;
    logic [12:0]        nsh;
    logic [63:0]        v;
    logic [63:0]        res;
    sh  = $signed({x.e[11], x.e}) + 13'sd32;
    nsh = $unsigned(-sh);
    v   = '0;
    if (sh >= 13'sd0) v = {32'b0, x.m} << sh[4:0];
    else if (nsh < 13'd64) v = {32'b0, x.m} >> nsh[5:0];
    res = x.neg ? (~v + 64'd1) : v;
    if (x.m == '0) res = '0;
    else if (sh > 13'sd31) res = x.neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/nbf_dist.sv =====
// ---------------------------------------------------------------------------
// nbf_dist
// Displacement, squared distance, cutoff test and range normalization.
// ---------------------------------------------------------------------------
`default_nettype none

module nbf_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] atom_a_x,
  input  logic signed [31:0] atom_a_y,
  input  logic signed [31:0] atom_a_z,
  input  logic signed [31:0] atom_b_x,
  input  logic signed [31:0] atom_b_y,
  input  logic signed [31:0] atom_b_z,
  input  logic signed [15:0] charge_a,
  input  logic signed [15:0] charge_b,
  input  logic [15:0]        sigma_nm,
  input  logic [23:0]        epsilon_kj,
  input  logic               one_four_pair,
  input  logic               lj_excluded,
  input  logic [30:0]        cutoff,
  output logic               valid_o,
  output nbf_pkg::pipe_t     pipe_o
);
  import nbf_pkg::*;

  pipe_t              s_r   [DIST_ST];
  pipe_t              s_nxt [DIST_ST];
  logic [DIST_ST-1:0] v_r;

  logic signed [32:0] ndx, ndy, ndz;
  logic signed [31:0] nq;
  logic [31:0]        mgx, mgy, mgz, aqp;
  logic [6:0]         bl;
  logic [65:0]        shv;

  always_comb begin
    s_nxt[0]         = '0;
    s_nxt[0].dx      = {atom_a_x[31], atom_a_x} - {atom_b_x[31], atom_b_x};
    s_nxt[0].dy      = {atom_a_y[31], atom_a_y} - {atom_b_y[31], atom_b_y};
    s_nxt[0].dz      = {atom_a_z[31], atom_a_z} - {atom_b_z[31], atom_b_z};
    s_nxt[0].qp      = 32'(charge_a) * 32'(charge_b);
    s_nxt[0].sg2     = 32'(sigma_nm) * 32'(sigma_nm);
    s_nxt[0].eps     = epsilon_kj;
    s_nxt[0].onefour = one_four_pair;
    s_nxt[0].ljx     = lj_excluded;

    // magnitudes and squares
    s_nxt[1]      = s_r[0];
    ndx           = -s_r[0].dx;
    ndy           = -s_r[0].dy;
    ndz           = -s_r[0].dz;
    nq            = -s_r[0].qp;
    mgx           = s_r[0].dx[32] ? ndx[31:0] : s_r[0].dx[31:0];
    mgy           = s_r[0].dy[32] ? ndy[31:0] : s_r[0].dy[31:0];
    mgz           = s_r[0].dz[32] ? ndz[31:0] : s_r[0].dz[31:0];
    aqp           = s_r[0].qp[31] ? nq : s_r[0].qp;
    s_nxt[1].mx   = mgx;
    s_nxt[1].my   = mgy;
    s_nxt[1].mz   = mgz;
    s_nxt[1].sqx  = 64'(mgx) * 64'(mgx);
    s_nxt[1].sqy  = 64'(mgy) * 64'(mgy);
    s_nxt[1].sqz  = 64'(mgz) * 64'(mgz);
    s_nxt[1].qq   = fnorm({32'b0, aqp}, -12'sd24, s_r[0].qp[31]);
    s_nxt[1].sg2f = fnorm({32'b0, s_r[0].sg2}, -12'sd32, 1'b0);
    s_nxt[1].a    = fnorm({40'b0, s_r[0].eps}, s_r[0].onefour ? -12'sd15 : -12'sd14, 1'b0);

    s_nxt[2]     = s_r[1];
    s_nxt[2].rsq = 66'(s_r[1].sqx) + 66'(s_r[1].sqy) + 66'(s_r[1].sqz);
    s_nxt[2].fdx = fnorm({32'b0, s_r[1].mx}, -12'sd24, s_r[1].dx[32]);
    s_nxt[2].fdy = fnorm({32'b0, s_r[1].my}, -12'sd24, s_r[1].dy[32]);
    s_nxt[2].fdz = fnorm({32'b0, s_r[1].mz}, -12'sd24, s_r[1].dz[32]);

    // bit length picks an even exponent so the root lands on 32 bits
    s_nxt[3]        = s_r[2];
    s_nxt[3].coinc  = (s_r[2].rsq == '0);
    s_nxt[3].cut_ok = (s_r[2].rsq <= {11'b0, cutoff, 24'b0});
    bl = '0;
    for (int i = 0; i < 66; i++) begin
      if (s_r[2].rsq[i]) bl = 7'(i + 1);
    end
    s_nxt[3].k = bl[0] ? ($signed({1'b0, bl}) - 8'sd63) : ($signed({1'b0, bl}) - 8'sd64);

    s_nxt[4] = s_r[3];
    if (s_r[3].k > 8'sd0) shv = s_r[3].rsq >> $unsigned(s_r[3].k);
    else shv = s_r[3].rsq << $unsigned(-s_r[3].k);
    s_nxt[4].mm = shv[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIST_ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign valid_o = v_r[DIST_ST-1];
  assign pipe_o  = s_r[DIST_ST-1];

endmodule

`default_nettype wire

// ===== hdl/nbf_sqrt.sv =====
// ---------------------------------------------------------------------------
// nbf_sqrt
// Pipelined digit-by-digit integer square root of the normalized squared distance.
// ---------------------------------------------------------------------------
`default_nettype none

module nbf_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  nbf_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output nbf_pkg::pipe_t pipe_o
);
  import nbf_pkg::*;

  pipe_t            stg [SQ_ST+1];
  logic [SQ_ST-1:0] v_r;

  assign stg[0] = pipe_i;

  for (genvar g = 0; g < SQ_ST; g++) begin : g_st
    pipe_t       nx;
    pipe_t       st_r;
    logic [34:0] rem;
    logic [33:0] trial;

    always_comb begin
      nx    = stg[g];
      rem   = '0;
      trial = '0;
      if (g == 0) begin
        nx.srem = '0;
        nx.root = '0;
      end
      // two radicand bits per step
      for (int j = 0; j < SQ_STEP; j++) begin
        rem   = {nx.srem[32:0], nx.mm[2*(31 - SQ_STEP*g - j) + 1 -: 2]};
        trial = {nx.root, 2'b01};
        if (rem >= {1'b0, trial}) begin
          nx.srem = rem - {1'b0, trial};
          nx.root = {nx.root[30:0], 1'b1};
        end else begin
          nx.srem = rem;
          nx.root = {nx.root[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r <= nx;
      end
    end

    assign stg[g+1] = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_ST-2:0], valid_i};
    end
  end

  assign valid_o = v_r[SQ_ST-1];
  assign pipe_o  = stg[SQ_ST];

endmodule

`default_nettype wire

// ===== hdl/nbf_recip.sv =====
// ---------------------------------------------------------------------------
// nbf_recip
// Pipelined restoring dividers for 1/r and 1/r^2.
// ---------------------------------------------------------------------------
`default_nettype none

module nbf_recip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  nbf_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output nbf_pkg::pipe_t pipe_o
);
  import nbf_pkg::*;

  localparam int NS = DV_ST + 2;

  pipe_t         stg [NS+1];
  logic [NS-1:0] v_r;

  assign stg[0] = pipe_i;

  for (genvar g = 0; g < NS; g++) begin : g_st
    pipe_t              nx;
    pipe_t              st_r;
    logic signed [11:0] e2;
    logic signed [11:0] eq;
    logic [32:0]        t1;
    logic [32:0]        t2;

    always_comb begin
      nx = stg[g];
      e2 = '0;
      eq = '0;
      t1 = '0;
      t2 = '0;
      if (g == 0) begin
        // floats for r and r^2, then divider setup for 2^63 / m
        e2         = $signed({{4{nx.k[7]}}, nx.k}) - 12'sd48;
        nx.r2.neg  = 1'b0;
        nx.r2.m    = nx.mm[63] ? nx.mm[63:32] : nx.mm[62:31];
        nx.r2.e    = e2 + (nx.mm[63] ? 12'sd32 : 12'sd31);
        nx.r.neg   = 1'b0;
        nx.r.m     = nx.root;
        nx.r.e     = e2 >>> 1;
        nx.q1      = {(nx.r.m <= 32'h8000_0000), 32'b0};
        nx.q2      = {(nx.r2.m <= 32'h8000_0000), 32'b0};
        nx.rem1    = 32'h8000_0000 - (nx.q1[32] ? nx.r.m : 32'b0);
        nx.rem2    = 32'h8000_0000 - (nx.q2[32] ? nx.r2.m : 32'b0);
      end else if (g == NS - 1) begin
        eq        = -12'sd63 - nx.r.e;
        nx.ir.neg = 1'b0;
        nx.ir.m   = nx.q1[32] ? 32'h8000_0000 : nx.q1[31:0];
        nx.ir.e   = nx.q1[32] ? eq + 12'sd1 : eq;
        eq        = -12'sd63 - nx.r2.e;
        nx.ir2.neg = 1'b0;
        nx.ir2.m  = nx.q2[32] ? 32'h8000_0000 : nx.q2[31:0];
        nx.ir2.e  = nx.q2[32] ? eq + 12'sd1 : eq;
      end else begin
        for (int j = 0; j < DV_STEP; j++) begin
          t1 = {nx.rem1, 1'b0};
          t2 = {nx.rem2, 1'b0};
          if (t1 >= {1'b0, nx.r.m}) begin
            nx.rem1 = 32'(t1 - {1'b0, nx.r.m});
            nx.q1[31 - DV_STEP*(g-1) - j] = 1'b1;
          end else begin
            nx.rem1 = t1[31:0];
          end
          if (t2 >= {1'b0, nx.r2.m}) begin
            nx.rem2 = 32'(t2 - {1'b0, nx.r2.m});
            nx.q2[31 - DV_STEP*(g-1) - j] = 1'b1;
          end else begin
            nx.rem2 = t2[31:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r <= nx;
      end
    end

    assign stg[g+1] = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], valid_i};
    end
  end

  assign valid_o = v_r[NS-1];
  assign pipe_o  = stg[NS];

endmodule

`default_nettype wire

// ===== hdl/nbf_energy.sv =====
// ---------------------------------------------------------------------------
// nbf_energy
// Float chain for Coulomb and LJ energies and the force components.
// ---------------------------------------------------------------------------
`default_nettype none

module nbf_energy (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  nbf_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output nbf_pkg::pipe_t pipe_o
);
  import nbf_pkg::*;

  pipe_t            e_r   [EN_ST];
  pipe_t            e_nxt [EN_ST];
  logic [EN_ST-1:0] v_r;
  logic             ljon;

  always_comb begin
    e_nxt[0]    = pipe_i;
    e_nxt[0].ec = fmul(F_KC, pipe_i.qq);
    e_nxt[0].u  = fmul(pipe_i.sg2f, pipe_i.ir2);

    e_nxt[1]    = e_r[0];
    e_nxt[1].ec = e_r[0].onefour ? fmul(e_r[0].ec, F_EL14) : e_r[0].ec;
    e_nxt[1].uu = fmul(e_r[0].u, e_r[0].u);

    e_nxt[2]    = e_r[1];
    e_nxt[2].ec = fmul(e_r[1].ec, e_r[1].ir);
    e_nxt[2].u3 = fmul(e_r[1].uu, e_r[1].u);

    e_nxt[3]      = e_r[2];
    e_nxt[3].coef = fmul(e_r[2].ec, e_r[2].ir2);
    e_nxt[3].au3  = fmul(e_r[2].a, e_r[2].u3);
    e_nxt[3].x12  = fmul(e_r[2].u3, F_C12);

    e_nxt[4]    = e_r[3];
    e_nxt[4].p1 = fadd_pre(e_r[3].u3, F_M1);
    e_nxt[4].p2 = fadd_pre(e_r[3].x12, F_M6);

    e_nxt[5]      = e_r[4];
    e_nxt[5].u3m1 = fadd_post(e_r[4].p1);
    e_nxt[5].t    = fadd_post(e_r[4].p2);

    e_nxt[6]      = e_r[5];
    e_nxt[6].el   = fmul(e_r[5].au3, e_r[5].u3m1);
    e_nxt[6].au3t = fmul(e_r[5].au3, e_r[5].t);

    e_nxt[7]     = e_r[6];
    e_nxt[7].ljf = fmul(e_r[6].au3t, e_r[6].ir2);

    // LJ force joins only inside the cutoff and when not excluded
    e_nxt[8] = e_r[7];
    ljon     = e_r[7].cut_ok & ~e_r[7].ljx;
    if (ljon) begin
      e_nxt[8].cp = fadd_pre(e_r[7].coef, e_r[7].ljf);
    end else begin
      e_nxt[8].cp     = '0;
      e_nxt[8].cp.byp = 1'b1;
      e_nxt[8].cp.bv  = e_r[7].coef;
    end

    e_nxt[9]      = e_r[8];
    e_nxt[9].coef = fadd_post(e_r[8].cp);

    e_nxt[10]    = e_r[9];
    e_nxt[10].fx = fmul(e_r[9].coef, e_r[9].fdx);
    e_nxt[10].fy = fmul(e_r[9].coef, e_r[9].fdy);
    e_nxt[10].fz = fmul(e_r[9].coef, e_r[9].fdz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[EN_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
    end
  end

  assign valid_o = v_r[EN_ST-1];
  assign pipe_o  = e_r[EN_ST-1];

endmodule

`default_nettype wire

// ===== hdl/nonbonded_pair_force.sv =====
// ---------------------------------------------------------------------------
// nonbonded_pair_force
// Coulomb plus Lennard-Jones energy and force for one atom pair per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one atom pair per word (valid/ready). Positions Q7.24 nm,
//            charges Q3.12, sigma Q0.16, epsilon Q8.16, 1-4 and LJ-excluded flags.
//   out_*  : energies and force on the first atom, Q31.32, saturating; plus
//            within_cutoff and coincident flags. One result word per input word.
//   cfg_*  : write channel for the squared LJ cutoff (Q7.24 nm^2); always ready.
//            Write it only while the pipe is empty.
// From accept to out_valid a word passes 5 distance stages, 8 square root
// stages (4 root bits each), 10 divider stages (setup, 8 stages of 4 quotient
// bits, normalize), 11 float stages and the output register.
// One word is accepted per cycle while the output is not stalled.
// A stall on out_ready freezes the whole pipe and drops in_ready; nothing is
// lost or repeated. Reset clears all valid bits and loads the cutoff with
// 1.0 nm^2.
// ---------------------------------------------------------------------------
`default_nettype none

module nonbonded_pair_force (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_atom_a_x,
  input  logic signed [31:0] in_atom_a_y,
  input  logic signed [31:0] in_atom_a_z,
  input  logic signed [31:0] in_atom_b_x,
  input  logic signed [31:0] in_atom_b_y,
  input  logic signed [31:0] in_atom_b_z,
  input  logic signed [15:0] in_charge_a,
  input  logic signed [15:0] in_charge_b,
  input  logic [15:0]        in_sigma_nm,
  input  logic [23:0]        in_epsilon_kj,
  input  logic               in_one_four_pair,
  input  logic               in_lj_excluded,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_coulomb_energy,
  output logic signed [63:0] out_lj_energy,
  output logic signed [63:0] out_force_x,
  output logic signed [63:0] out_force_y,
  output logic signed [63:0] out_force_z,
  output logic               out_within_cutoff,
  output logic               out_coincident,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_cutoff_squared
);
  import nbf_pkg::*;

  logic        en;
  logic [30:0] cutoff_r;
  logic        out_valid_r;

  logic        d_valid, s_valid, r_valid, e_valid;
  pipe_t       d_pipe, s_pipe, r_pipe, e_pipe;

  logic [63:0] ce_r, le_r, fx_r, fy_r, fz_r;
  logic [63:0] ce_nxt, le_nxt, fx_nxt, fy_nxt, fz_nxt;
  logic        wc_r, co_r;
  logic        ljon;

  assign en        = ~out_valid_r | out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 31'd16777216;
    end else if (cfg_valid) begin
      cutoff_r <= cfg_cutoff_squared;
    end
  end

  nbf_dist u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .atom_a_x      (in_atom_a_x),
    .atom_a_y      (in_atom_a_y),
    .atom_a_z      (in_atom_a_z),
    .atom_b_x      (in_atom_b_x),
    .atom_b_y      (in_atom_b_y),
    .atom_b_z      (in_atom_b_z),
    .charge_a      (in_charge_a),
    .charge_b      (in_charge_b),
    .sigma_nm      (in_sigma_nm),
    .epsilon_kj    (in_epsilon_kj),
    .one_four_pair (in_one_four_pair),
    .lj_excluded   (in_lj_excluded),
    .cutoff        (cutoff_r),
    .valid_o       (d_valid),
    .pipe_o        (d_pipe)
  );

  nbf_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (d_valid),
    .pipe_i  (d_pipe),
    .valid_o (s_valid),
    .pipe_o  (s_pipe)
  );

  nbf_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_valid),
    .pipe_i  (s_pipe),
    .valid_o (r_valid),
    .pipe_o  (r_pipe)
  );

  nbf_energy u_energy (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (r_valid),
    .pipe_i  (r_pipe),
    .valid_o (e_valid),
    .pipe_o  (e_pipe)
  );

  always_comb begin
    ljon   = e_pipe.cut_ok & ~e_pipe.ljx;
    ce_nxt = to_q32(e_pipe.ec);
    le_nxt = ljon ? to_q32(e_pipe.el) : 64'd0;
    fx_nxt = to_q32(e_pipe.fx);
    fy_nxt = to_q32(e_pipe.fy);
    fz_nxt = to_q32(e_pipe.fz);
    if (e_pipe.coinc) begin
      ce_nxt = '0;
      le_nxt = '0;
      fx_nxt = '0;
      fy_nxt = '0;
      fz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ce_r <= ce_nxt;
      le_r <= le_nxt;
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      fz_r <= fz_nxt;
      wc_r <= e_pipe.cut_ok;
      co_r <= e_pipe.coinc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coulomb_energy = ce_r;
  assign out_lj_energy      = le_r;
  assign out_force_x        = fx_r;
  assign out_force_y        = fy_r;
  assign out_force_z        = fz_r;
  assign out_within_cutoff  = wc_r;
  assign out_coincident     = co_r;

endmodule

`default_nettype wire

// ===== tb/tb_nonbonded_pair_force.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nonbonded_pair_force
// Self-checking bench for the Coulomb + Lennard-Jones pair force pipe. A
// bit-exact software copy of the block's float arithmetic predicts every
// result word; directed pairs, random pairs, cutoff changes, random idling
// on both sides, a long output stall and a full drain pause are exercised.
// ---------------------------------------------------------------------------

module tb_nonbonded_pair_force;
  import nbf_pkg::*;

  typedef struct {
    bit signed [31:0] ax, ay, az, bx, by, bz;
    bit signed [15:0] qa, qb;
    bit [15:0]        sigma;
    bit [23:0]        eps;
    bit               onefour;
    bit               ljx;
  } pair_t;

  typedef struct {
    bit [63:0] ecoul, elj, fx, fy, fz;
    bit        cut_ok, coinc;
  } pair_result_t;

  // mantissa in [2^31, 2^32) or zero; value = m * 2^e
  typedef struct {
    bit [31:0] m;
    int        e;
    bit        neg;
  } fnum_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_atom_a_x, in_atom_a_y, in_atom_a_z;
  logic signed [31:0] in_atom_b_x, in_atom_b_y, in_atom_b_z;
  logic signed [15:0] in_charge_a, in_charge_b;
  logic [15:0]        in_sigma_nm;
  logic [23:0]        in_epsilon_kj;
  logic               in_one_four_pair;
  logic               in_lj_excluded;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_coulomb_energy, out_lj_energy;
  logic signed [63:0] out_force_x, out_force_y, out_force_z;
  logic               out_within_cutoff;
  logic               out_coincident;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [30:0]        cfg_cutoff_squared;

  pair_result_t pending_forces[$];
  bit [30:0]    cutoff_model;
  int           fail_count;
  bit           idle_on;
  bit           rx_hold_req;

  localparam int DRAIN_CYCLES = 60;

  nonbonded_pair_force DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_atom_a_x(in_atom_a_x), .in_atom_a_y(in_atom_a_y), .in_atom_a_z(in_atom_a_z),
    .in_atom_b_x(in_atom_b_x), .in_atom_b_y(in_atom_b_y), .in_atom_b_z(in_atom_b_z),
    .in_charge_a(in_charge_a), .in_charge_b(in_charge_b),
    .in_sigma_nm(in_sigma_nm), .in_epsilon_kj(in_epsilon_kj),
    .in_one_four_pair(in_one_four_pair), .in_lj_excluded(in_lj_excluded),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_coulomb_energy(out_coulomb_energy), .out_lj_energy(out_lj_energy),
    .out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
    .out_within_cutoff(out_within_cutoff), .out_coincident(out_coincident),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_cutoff_squared(cfg_cutoff_squared)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- float arithmetic copy ----------------
  function automatic fnum_t fn_norm(bit [63:0] m, int e, bit neg);
    fnum_t r;
    r = '{0, 0, 1'b0};
    if (m == 0) return r;
    while (m[63:32] != 0) begin
      m = m >> 1;
      e++;
    end
    while (!m[31]) begin
      m = m << 1;
      e--;
    end
    r.m = m[31:0];
    r.e = e;
    r.neg = neg;
    return r;
  endfunction

  function automatic fnum_t fn_mul(fnum_t a, fnum_t b);
    return fn_norm(64'(a.m) * 64'(b.m), a.e + b.e, a.neg ^ b.neg);
  endfunction

  function automatic fnum_t fn_div(fnum_t a, fnum_t b);
    if (b.m == 0) return fn_norm(0, 0, 1'b0);
    return fn_norm({a.m, 32'b0} / 64'(b.m), a.e - b.e - 32, a.neg ^ b.neg);
  endfunction

  function automatic fnum_t fn_add(fnum_t a, fnum_t b);
    bit [63:0] ma, mb;
    int        d, e;
    if (a.m == 0) return b;
    if (b.m == 0) return a;
    ma = 64'(a.m) << 30;
    mb = 64'(b.m) << 30;
    d = a.e - b.e;
    if (d >= 0) begin
      e = a.e;
      mb = (d >= 63) ? 64'd0 : (mb >> d);
    end else begin
      e = b.e;
      ma = (-d >= 63) ? 64'd0 : (ma >> (-d));
    end
    if (a.neg == b.neg) return fn_norm(ma + mb, e - 30, a.neg);
    if (ma >= mb) return fn_norm(ma - mb, e - 30, a.neg);
    return fn_norm(mb - ma, e - 30, b.neg);
  endfunction

  function automatic bit [63:0] fn_to_fixed(fnum_t x);
    int        sh;
    bit [63:0] v;
    if (x.m == 0) return 64'd0;
    sh = x.e + 32;
    if (sh > 31) return x.neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (sh >= 0) v = 64'(x.m) << sh;
    else if (-sh >= 64) v = 64'd0;
    else v = 64'(x.m) >> (-sh);
    return x.neg ? (~v + 64'd1) : v;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic pair_result_t compute_pair_force(pair_t p, bit [30:0] cut);
    pair_result_t res;
    longint       dv[3];
    bit [63:0]    dm[3];
    bit [65:0]    rsq;
    bit [63:0]    mm;
    int           plen, k, qp;
    fnum_t        one, r, r2, ir, ir2, qq, ec, coef, el, u, u3, a, t;
    dv[0] = longint'(p.ax) - longint'(p.bx);
    dv[1] = longint'(p.ay) - longint'(p.by);
    dv[2] = longint'(p.az) - longint'(p.bz);
    rsq = 0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = (dv[i] < 0) ? 64'(-dv[i]) : 64'(dv[i]);
      rsq = rsq + 66'(dm[i] * dm[i]);
    end
    res.coinc = (rsq == 0);
    res.cut_ok = (rsq <= (66'(cut) << 24));
    res.ecoul = 0;
    res.elj = 0;
    res.fx = 0;
    res.fy = 0;
    res.fz = 0;
    if (res.coinc) return res;

    plen = 0;
    for (int i = 0; i < 66; i++) if (rsq[i]) plen = i + 1;
    k = (((plen - 64) % 2) == 0) ? plen - 64 : plen - 63;
    if (k > 0) mm = 64'(rsq >> k);
    else if (k < 0) mm = rsq[63:0] << (-k);
    else mm = rsq[63:0];

    one = fn_norm(1, 0, 1'b0);
    r2 = fn_norm(mm, k - 48, 1'b0);
    r = fn_norm(int_sqrt(mm), (k - 48) / 2, 1'b0);
    ir = fn_div(one, r);
    ir2 = fn_div(one, r2);

    qp = int'(p.qa) * int'(p.qb);
    qq = fn_norm((qp < 0) ? 64'(-longint'(qp)) : 64'(qp), -24, qp < 0);
    ec = fn_mul(fn_norm(64'd2330950189, -24, 1'b0), qq);
    if (p.onefour) ec = fn_mul(ec, fn_norm(64'd13980454, -24, 1'b0));
    ec = fn_mul(ec, ir);
    coef = fn_mul(ec, ir2);
    el = fn_norm(0, 0, 1'b0);

    if (res.cut_ok && !p.ljx) begin
      u = fn_mul(fn_norm(64'(p.sigma) * 64'(p.sigma), -32, 1'b0), ir2);
      u3 = fn_mul(fn_mul(u, u), u);
      a = fn_norm(64'(p.eps), p.onefour ? -15 : -14, 1'b0);
      el = fn_mul(fn_mul(a, u3), fn_add(u3, fn_norm(1, 0, 1'b1)));
      t = fn_add(fn_mul(u3, fn_norm(12, 0, 1'b0)), fn_norm(6, 0, 1'b1));
      coef = fn_add(coef, fn_mul(fn_mul(fn_mul(a, u3), t), ir2));
    end

    res.ecoul = fn_to_fixed(ec);
    res.elj = fn_to_fixed(el);
    res.fx = fn_to_fixed(fn_mul(coef, fn_norm(dm[0], -24, dv[0] < 0)));
    res.fy = fn_to_fixed(fn_mul(coef, fn_norm(dm[1], -24, dv[1] < 0)));
    res.fz = fn_to_fixed(fn_mul(coef, fn_norm(dm[2], -24, dv[2] < 0)));
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_pair(pair_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_atom_a_x = p.ax; in_atom_a_y = p.ay; in_atom_a_z = p.az;
    in_atom_b_x = p.bx; in_atom_b_y = p.by; in_atom_b_z = p.bz;
    in_charge_a = p.qa; in_charge_b = p.qb;
    in_sigma_nm = p.sigma; in_epsilon_kj = p.eps;
    in_one_four_pair = p.onefour; in_lj_excluded = p.ljx;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_forces.push_back(compute_pair_force(p, cutoff_model));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cutoff(bit [30:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_cutoff_squared = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cutoff_model = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly close pairs so the LJ term and cutoff boundary get exercised
  function automatic pair_t rand_pair();
    pair_t p;
    int    sh;
    p.qa = 16'($urandom);
    p.qb = 16'($urandom);
    p.sigma = 16'($urandom);
    p.eps = 24'($urandom);
    p.onefour = 1'($urandom_range(0, 1));
    p.ljx = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0, 1: begin
        p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
        p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
      end
      2: begin
        p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
        p.bx = p.ax; p.by = p.ay; p.bz = p.az;
      end
      default: begin
        sh = $urandom_range(4, 26);
        p.ax = $signed($urandom) >>> 2;
        p.ay = $signed($urandom) >>> 2;
        p.az = $signed($urandom) >>> 2;
        p.bx = p.ax + ($signed($urandom) >>> (32 - sh));
        p.by = p.ay + ($signed($urandom) >>> (32 - sh));
        p.bz = p.az + ($signed($urandom) >>> (32 - sh));
        // sigma near the distance makes the repulsive part matter
        if ($urandom_range(0, 1)) p.sigma = 16'($urandom_range(8000, 30000));
        if ($urandom_range(0, 1)) p.eps = 24'($urandom_range(0, 2000000));
      end
    endcase
    return p;
  endfunction

  // ---------------- result checking ----------------
  function automatic void check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pair_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = pending_forces.pop_front();
        check_field("coulomb_energy", e.ecoul, out_coulomb_energy);
        check_field("lj_energy", e.elj, out_lj_energy);
        check_field("force_x", e.fx, out_force_x);
        check_field("force_y", e.fy, out_force_y);
        check_field("force_z", e.fz, out_force_z);
        check_field("within_cutoff", 64'(e.cut_ok), 64'(out_within_cutoff));
        check_field("coincident", 64'(e.coinc), 64'(out_coincident));
      end
    end
  end

  // receiver: random per-word gaps, plus one long hold on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    pair_t p;
    p = '{ax: 0, ay: 0, az: 0, bx: 32'sd5033165, by: 0, bz: 0,
          qa: 16'sd4096, qb: -16'sd4096, sigma: 16'd20000, eps: 24'd65536,
          onefour: 0, ljx: 0};
    send_pair(p);                                   // ordinary close pair
    p.onefour = 1; send_pair(p);                    // 1-4 scaling
    p.ljx = 1; send_pair(p);                        // LJ excluded
    p.onefour = 0; p.ljx = 0;
    p.sigma = 0; send_pair(p);                      // zero sigma
    p.sigma = 16'hffff; p.eps = 0; send_pair(p);    // zero epsilon
    p.eps = 24'hffffff; send_pair(p);               // max epsilon, max sigma
    p.bx = 32'sd16777216; send_pair(p);             // exactly on the 1 nm cutoff
    p.bx = 32'sd16777217; send_pair(p);             // just past it
    p.bx = 32'sd1; send_pair(p);                    // tiny distance, saturation
    p.bx = 0; send_pair(p);                         // coincident
    p.qa = 16'sh7fff; p.qb = 16'sh8000; p.bx = 32'sd3000000; send_pair(p);
    p.qa = 16'sh8000; send_pair(p);                 // charge extremes
    p.qa = 0; send_pair(p);                         // no charge
    p.ax = 32'sh8000_0000; p.ay = 32'sh8000_0000; p.az = 32'sh8000_0000;
    p.bx = 32'sh7fff_ffff; p.by = 32'sh7fff_ffff; p.bz = 32'sh7fff_ffff;
    p.qa = 16'sh7fff; send_pair(p);                 // largest separation
    p.bx = p.ax; p.by = p.ay; p.bz = p.az; send_pair(p);
    p.ax = 32'sh7fff_ffff; p.bx = 32'sh8000_0000; p.by = 32'sh8000_0000 + 1;
    send_pair(p);
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 50) idle_on = ~idle_on;  // stretches without idling
      send_pair(rand_pair());
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_cutoff_sweep();
    set_cutoff(31'd0);
    test_random(100);
    set_cutoff(31'h7fff_ffff);
    test_random(150);
    set_cutoff(31'($urandom));
    test_random(100);
    set_cutoff(31'($urandom_range(1000000, 40000000)));
    test_random(150);
    set_cutoff(31'd16777216);
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_pair(rand_pair());
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 60; i++) send_pair(rand_pair());
    stop_sending();
    while (pending_forces.size() != 0) @(posedge clk);
    for (int i = 0; i < 60; i++) send_pair(rand_pair());
    wait_drained();
  endtask

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_atom_a_x = 0; in_atom_a_y = 0; in_atom_a_z = 0;
    in_atom_b_x = 0; in_atom_b_y = 0; in_atom_b_z = 0;
    in_charge_a = 0; in_charge_b = 0;
    in_sigma_nm = 0; in_epsilon_kj = 0;
    in_one_four_pair = 0; in_lj_excluded = 0;
    cfg_valid = 1'b0;
    cfg_cutoff_squared = 0;
    cutoff_model = 31'd16777216;
    fail_count = 0;
    idle_on = 1'b1;
    rx_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(600);
    test_cutoff_sweep();
    test_output_stall();
    test_sender_pause();
    test_random(300);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
